### rtl/ils_pkg.sv
// types, constants and digit helpers for the integer literal scanner
// no dependencies; imported by integer_literal_scanner

package ils_pkg;

	localparam int unsigned CNT_W   = 9;
	localparam int unsigned POS_W   = 9;
	localparam int unsigned ACC_W   = 64;
	localparam int unsigned NUM_ALT = 4;

	localparam int unsigned DEF_MAX_BIN_DIGITS = 256;
	localparam int unsigned DEF_MAX_OCT_DIGITS = 24;
	localparam int unsigned DEF_MAX_HEX_DIGITS = 20;
	localparam int unsigned DEF_MAX_DEC_DIGITS = 20;

	localparam logic [POS_W-1:0] POS_MAX = '1;

	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_SEVEN = 8'h37;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;

	typedef enum logic [1:0] {
		KIND_BIN = 2'd0,
		KIND_OCT = 2'd1,
		KIND_HEX = 2'd2,
		KIND_DEC = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_RUN   = 3'b001,
		ST_MATCH = 3'b010,
		ST_FAIL  = 3'b100
	} status_t;

	typedef struct packed {
		logic [ACC_W-1:0] acc;
		logic [CNT_W-1:0] cnt;
		status_t          st;
		logic [POS_W-1:0] endp;
		logic             ovf;
	} alt_t;

	localparam alt_t ALT_CLEAR = '{acc: '0, cnt: '0, st: ST_RUN, endp: '0, ovf: 1'b0};

	// hex digit decode: bit 4 is valid
	function automatic logic [4:0] hex_value(logic [7:0] c);
		logic [4:0] v;
		v = '0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			v = {1'b1, 4'(c - CH_ZERO)};
		end else if (c >= CH_LA && c <= CH_LF) begin
			v = {1'b1, 4'(c - CH_LA + 8'd10)};
		end else if (c >= CH_UA && c <= CH_UF) begin
			v = {1'b1, 4'(c - CH_UA + 8'd10)};
		end
		return v;
	endfunction

	// acc = acc * radix + d, with sticky wrap flag
	function automatic alt_t take_digit(alt_t a, logic [3:0] d, kind_t rk);
		alt_t b;
		logic [ACC_W+3:0] wide;
		b = a;
		wide = '0;
		unique case (rk)
			KIND_BIN: begin
				wide = {3'b0, a.acc, 1'b0} + (ACC_W+4)'(d);
			end
			KIND_OCT: begin
				wide = {1'b0, a.acc, 3'b0} + (ACC_W+4)'(d);
			end
			KIND_HEX: begin
				wide = {a.acc, 4'b0} + (ACC_W+4)'(d);
			end
			KIND_DEC: begin
				wide = {1'b0, a.acc, 3'b0} + {3'b0, a.acc, 1'b0} + (ACC_W+4)'(d);
			end
			default: begin
				wide = '0;
			end
		endcase
		if (wide[ACC_W+3:ACC_W] != '0)
			b.ovf = 1'b1;
		b.acc = wide[ACC_W-1:0];
		b.cnt = a.cnt + CNT_W'(1);
		return b;
	endfunction

	// greedy bounded repeat of digits
	function automatic alt_t repeat_step(alt_t a, logic ok, logic [3:0] d, kind_t rk,
			logic [CNT_W-1:0] limit, logic [POS_W-1:0] pos);
		alt_t b;
		b = a;
		if (ok && a.cnt < limit) begin
			b = take_digit(a, d, rk);
			if (b.cnt >= limit) begin
				b.st   = ST_MATCH;
				b.endp = pos + POS_W'(1);
			end
		end else if (a.cnt != '0) begin
			b.st   = ST_MATCH;
			b.endp = pos;
		end else begin
			b.st = ST_FAIL;
		end
		return b;
	endfunction

endpackage

### rtl/integer_literal_scanner.sv
// integer literal scanner top level: sign, binary, octal, hex and decimal forms
// depends on ils_pkg
//
// usage: characters arrive one beat each on the item channel (character,
// first_char, last_char). first_char starts a new attempt; last_char ends the
// text and yields one beat on the result channel (matched, radix_kind,
// match_length, magnitude, negative, overflowed). other beats yield nothing.
// an input register feeds the scan state; all four forms are updated in the
// same cycle with shift-and-add logic, and a result register holds the outcome.
// a last_char beat passes through the input register and then the result register before its result shows.
// throughput: one character per cycle while results are taken.
// after a last_char beat the scan state is cleared, so the next character
// starts a new attempt.
// reset clears the scan state and both valid flags.
// when the receiver stalls, characters keep flowing until a second last_char
// beat reaches the input register; it then waits there and item_ready drops
// until the pending result is taken.

module integer_literal_scanner
	import ils_pkg::*;
#(
	parameter int unsigned MAX_BIN_DIGITS = DEF_MAX_BIN_DIGITS,
	parameter int unsigned MAX_OCT_DIGITS = DEF_MAX_OCT_DIGITS,
	parameter int unsigned MAX_HEX_DIGITS = DEF_MAX_HEX_DIGITS,
	parameter int unsigned MAX_DEC_DIGITS = DEF_MAX_DEC_DIGITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  logic [7:0]       character,
	input  logic             first_char,
	input  logic             last_char,
	output logic             result_valid,
	input  logic             result_ready,
	output logic             matched,
	output logic [1:0]       radix_kind,
	output logic [8:0]       match_length,
	output logic [ACC_W-1:0] magnitude,
	output logic             negative,
	output logic             overflowed
);

	localparam logic [CNT_W-1:0] LIM_BIN = CNT_W'(MAX_BIN_DIGITS);
	localparam logic [CNT_W-1:0] LIM_OCT = CNT_W'(MAX_OCT_DIGITS);
	localparam logic [CNT_W-1:0] LIM_HEX = CNT_W'(MAX_HEX_DIGITS);
	localparam logic [CNT_W-1:0] LIM_DEC = CNT_W'(MAX_DEC_DIGITS);

	// input register
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       first_s1;
	logic       last_s1;

	// scan state
	logic [POS_W-1:0] pos_q;
	logic             minus_q;
	logic             sgn_off_q;
	alt_t             alt_q [NUM_ALT];

	// result register
	logic             res_valid_q;
	logic             matched_q;
	kind_t            kind_q;
	logic [POS_W-1:0] len_q;
	logic [ACC_W-1:0] mag_q;
	logic             neg_q;
	logic             ovf_q;

	logic advance;
	logic step;

	logic [POS_W-1:0] pos_c;
	logic             minus_c;
	logic             sgn_off_c;
	alt_t             cur [NUM_ALT];
	alt_t             nxt [NUM_ALT];
	alt_t             fin [NUM_ALT];
	logic             minus_n;
	logic             sgn_off_n;
	logic [POS_W-1:0] pos_n;
	logic [POS_W-1:0] rel;
	logic             is_dig;
	logic             is_oct;
	logic [4:0]       hv;

	logic             sel_hit;
	kind_t            sel_kind;
	logic [POS_W-1:0] sel_len;
	logic [ACC_W-1:0] sel_mag;
	logic             sel_ovf;

	assign advance    = !last_s1 || !res_valid_q || result_ready;
	assign item_ready = !valid_s1 || advance;
	assign step       = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			char_s1  <= character;
			first_s1 <= first_char;
			last_s1  <= last_char;
		end
	end

	// per-character update
	always_comb begin
		pos_c     = first_s1 ? '0 : pos_q;
		minus_c   = first_s1 ? 1'b0 : minus_q;
		sgn_off_c = first_s1 ? 1'b0 : sgn_off_q;
		for (int k = 0; k < NUM_ALT; k++) begin
			cur[k] = first_s1 ? ALT_CLEAR : alt_q[k];
			nxt[k] = cur[k];
		end
		minus_n   = minus_c;
		sgn_off_n = sgn_off_c;
		rel       = pos_c - POS_W'(sgn_off_c);
		is_dig    = (char_s1 >= CH_ZERO) && (char_s1 <= CH_NINE);
		is_oct    = (char_s1 >= CH_ZERO) && (char_s1 <= CH_SEVEN);
		hv        = hex_value(char_s1);

		if (pos_c == '0 && (char_s1 == CH_PLUS || char_s1 == CH_MINUS)) begin
			sgn_off_n = 1'b1;
			minus_n   = (char_s1 == CH_MINUS);
		end else begin
			if (cur[KIND_BIN].st == ST_RUN) begin
				if ((char_s1 == CH_ZERO || char_s1 == CH_ONE) && cur[KIND_BIN].cnt < LIM_BIN) begin
					nxt[KIND_BIN] = take_digit(cur[KIND_BIN], 4'(char_s1[0]), KIND_BIN);
				end else if (char_s1 == CH_B && cur[KIND_BIN].cnt != '0) begin
					nxt[KIND_BIN].st   = ST_MATCH;
					nxt[KIND_BIN].endp = pos_c + POS_W'(1);
				end else begin
					nxt[KIND_BIN].st = ST_FAIL;
				end
			end

			if (cur[KIND_OCT].st == ST_RUN) begin
				if (rel == '0) begin
					if (char_s1 != CH_ZERO)
						nxt[KIND_OCT].st = ST_FAIL;
				end else begin
					nxt[KIND_OCT] = repeat_step(cur[KIND_OCT], is_oct, char_s1[3:0],
						KIND_OCT, LIM_OCT, pos_c);
				end
			end

			if (cur[KIND_HEX].st == ST_RUN) begin
				if (rel == '0) begin
					if (char_s1 != CH_ZERO)
						nxt[KIND_HEX].st = ST_FAIL;
				end else if (rel == POS_W'(1)) begin
					if (char_s1 != CH_X)
						nxt[KIND_HEX].st = ST_FAIL;
				end else begin
					nxt[KIND_HEX] = repeat_step(cur[KIND_HEX], hv[4], hv[3:0],
						KIND_HEX, LIM_HEX, pos_c);
				end
			end

			if (cur[KIND_DEC].st == ST_RUN)
				nxt[KIND_DEC] = repeat_step(cur[KIND_DEC], is_dig, char_s1[3:0],
					KIND_DEC, LIM_DEC, pos_c);
		end

		pos_n = (pos_c < POS_MAX) ? pos_c + POS_W'(1) : POS_MAX;
	end

	// close forms at end of text and pick the first match
	always_comb begin
		for (int k = 0; k < NUM_ALT; k++) begin
			fin[k] = nxt[k];
			if (nxt[k].st == ST_RUN) begin
				if (k == int'(KIND_BIN) || nxt[k].cnt == '0) begin
					fin[k].st = ST_FAIL;
				end else begin
					fin[k].st   = ST_MATCH;
					fin[k].endp = pos_c + POS_W'(1);
				end
			end
		end
		sel_hit  = 1'b0;
		sel_kind = KIND_BIN;
		sel_len  = '0;
		sel_mag  = '0;
		sel_ovf  = 1'b0;
		for (int k = NUM_ALT - 1; k >= 0; k--) begin
			if (fin[k].st == ST_MATCH) begin
				sel_hit  = 1'b1;
				sel_kind = kind_t'(k[1:0]);
				sel_len  = fin[k].endp;
				sel_mag  = fin[k].acc;
				sel_ovf  = fin[k].ovf;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			minus_q   <= 1'b0;
			sgn_off_q <= 1'b0;
			for (int k = 0; k < NUM_ALT; k++)
				alt_q[k] <= ALT_CLEAR;
		end else if (step) begin
			if (last_s1) begin
				pos_q     <= '0;
				minus_q   <= 1'b0;
				sgn_off_q <= 1'b0;
				for (int k = 0; k < NUM_ALT; k++)
					alt_q[k] <= ALT_CLEAR;
			end else begin
				pos_q     <= pos_n;
				minus_q   <= minus_n;
				sgn_off_q <= sgn_off_n;
				for (int k = 0; k < NUM_ALT; k++)
					alt_q[k] <= nxt[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			matched_q <= sel_hit;
			kind_q    <= sel_kind;
			len_q     <= sel_len;
			mag_q     <= sel_mag;
			neg_q     <= sel_hit && minus_n;
			ovf_q     <= sel_ovf;
		end
	end

	assign result_valid = res_valid_q;
	assign matched      = matched_q;
	assign radix_kind   = kind_q;
	assign match_length = len_q;
	assign magnitude    = mag_q;
	assign negative     = neg_q;
	assign overflowed   = ovf_q;

	a_nomatch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !matched |-> radix_kind == KIND_BIN && match_length == '0
			&& magnitude == '0 && !negative && !overflowed)
		else $error("unmatched result carries nonzero fields");

	a_match_len: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && matched |-> match_length != '0)
		else $error("matched result with zero length");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && last_s1 |=> pos_q == '0 && !sgn_off_q && result_valid)
		else $error("end of text did not clear scan state or post a result");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> valid_s1 && last_s1 && result_valid && !result_ready)
		else $error("input stalled without a pending result");

endmodule

### tb/integer_literal_scanner_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for integer_literal_scanner: directed, limit and random literals
// against a cycle-free scan predictor; depends on ils_pkg and the scanner rtl

module integer_literal_scanner_tb;
	import ils_pkg::*;

	localparam int BIN_LIMIT     = DEF_MAX_BIN_DIGITS;
	localparam int OCT_LIMIT     = DEF_MAX_OCT_DIGITS;
	localparam int HEX_LIMIT     = DEF_MAX_HEX_DIGITS;
	localparam int DEC_LIMIT     = DEF_MAX_DEC_DIGITS;
	localparam int RANDOM_CHARS  = 460;
	localparam int BURST_CHARS   = 200;
	localparam int QUIET_LIMIT   = 1000;
	localparam int DRAIN_CYCLES  = 20;

	typedef struct packed {
		logic        hit;
		kind_t       kind;
		logic [8:0]  span;
		logic [63:0] value;
		logic        minus;
		logic        wrapped;
	} scan_result_t;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_ready;
	logic [7:0]  character;
	logic        first_char;
	logic        last_char;
	logic        result_valid;
	logic        result_ready;
	logic        matched;
	logic [1:0]  radix_kind;
	logic [8:0]  match_length;
	logic [63:0] magnitude;
	logic        negative;
	logic        overflowed;

	// scan state mirror
	logic [8:0]  scan_pos;
	logic        minus_flag;
	logic        sign_skip;
	logic [63:0] form_acc [4];
	int          form_cnt [4];
	status_t     form_st  [4];
	logic [8:0]  form_end [4];
	logic        form_ovf [4];

	scan_result_t expected_literals[$];
	logic [7:0]   lit_chars[$];
	bit           idling_on = 1'b1;
	int           chars_sent = 0;
	int           fail_count = 0;
	int           quiet_cycles = 0;

	integer_literal_scanner u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.character    (character),
		.first_char   (first_char),
		.last_char    (last_char),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.matched      (matched),
		.radix_kind   (radix_kind),
		.match_length (match_length),
		.magnitude    (magnitude),
		.negative     (negative),
		.overflowed   (overflowed)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void clear_scan();
		scan_pos   = '0;
		minus_flag = 1'b0;
		sign_skip  = 1'b0;
		for (int k = 0; k < 4; k++) begin
			form_acc[k] = '0;
			form_cnt[k] = 0;
			form_st[k]  = ST_RUN;
			form_end[k] = '0;
			form_ovf[k] = 1'b0;
		end
	endfunction

	function automatic void add_digit(int k, int d, int radix);
		logic [67:0] w;
		w = {4'b0, form_acc[k]} * 68'(radix) + 68'(d);
		if (w[67:64] != '0)
			form_ovf[k] = 1'b1;
		form_acc[k] = w[63:0];
		form_cnt[k]++;
	endfunction

	function automatic void greedy_digit(int k, bit ok, int d, int radix, int limit,
			logic [8:0] pos);
		if (ok && form_cnt[k] < limit) begin
			add_digit(k, d, radix);
			if (form_cnt[k] >= limit) begin
				form_st[k]  = ST_MATCH;
				form_end[k] = pos + 9'd1;
			end
		end else if (form_cnt[k] > 0) begin
			form_st[k]  = ST_MATCH;
			form_end[k] = pos;
		end else begin
			form_st[k] = ST_FAIL;
		end
	endfunction

	function automatic int hex_digit_value(logic [7:0] c);
		if (c >= CH_ZERO && c <= CH_NINE)
			return int'(c - CH_ZERO);
		if (c >= CH_LA && c <= CH_LF)
			return int'(c - CH_LA) + 10;
		if (c >= CH_UA && c <= CH_UF)
			return int'(c - CH_UA) + 10;
		return -1;
	endfunction

	// returns 1 when the character closes the text and yields a result
	function automatic bit predict_scan(logic [7:0] c, bit opens, bit closes,
			output scan_result_t res);
		logic [8:0] pos;
		int         r;
		int         hv;
		bit         dig;
		res = '0;
		if (opens)
			clear_scan();
		pos = scan_pos;
		dig = (c >= CH_ZERO && c <= CH_NINE);
		if (pos == 0 && (c == CH_PLUS || c == CH_MINUS)) begin
			sign_skip  = 1'b1;
			minus_flag = (c == CH_MINUS);
		end else begin
			r = int'(pos) - int'(sign_skip);
			if (form_st[KIND_BIN] == ST_RUN) begin
				if ((c == CH_ZERO || c == CH_ONE) && form_cnt[KIND_BIN] < BIN_LIMIT) begin
					add_digit(KIND_BIN, int'(c - CH_ZERO), 2);
				end else if (c == CH_B && form_cnt[KIND_BIN] > 0) begin
					form_st[KIND_BIN]  = ST_MATCH;
					form_end[KIND_BIN] = pos + 9'd1;
				end else begin
					form_st[KIND_BIN] = ST_FAIL;
				end
			end
			if (form_st[KIND_OCT] == ST_RUN) begin
				if (r == 0) begin
					if (c != CH_ZERO)
						form_st[KIND_OCT] = ST_FAIL;
				end else begin
					greedy_digit(KIND_OCT, c >= CH_ZERO && c <= CH_SEVEN,
						(c >= CH_ZERO && c <= CH_SEVEN) ? int'(c - CH_ZERO) : 0,
						8, OCT_LIMIT, pos);
				end
			end
			if (form_st[KIND_HEX] == ST_RUN) begin
				if (r == 0) begin
					if (c != CH_ZERO)
						form_st[KIND_HEX] = ST_FAIL;
				end else if (r == 1) begin
					if (c != CH_X)
						form_st[KIND_HEX] = ST_FAIL;
				end else begin
					hv = hex_digit_value(c);
					greedy_digit(KIND_HEX, hv >= 0, (hv >= 0) ? hv : 0, 16, HEX_LIMIT, pos);
				end
			end
			if (form_st[KIND_DEC] == ST_RUN)
				greedy_digit(KIND_DEC, dig, dig ? int'(c - CH_ZERO) : 0, 10, DEC_LIMIT, pos);
		end
		scan_pos = (pos < POS_MAX) ? pos + 9'd1 : POS_MAX;
		if (!closes)
			return 1'b0;
		for (int k = 0; k < 4; k++) begin
			if (form_st[k] == ST_RUN) begin
				if (k == KIND_BIN || form_cnt[k] == 0) begin
					form_st[k] = ST_FAIL;
				end else begin
					form_st[k]  = ST_MATCH;
					form_end[k] = pos + 9'd1;
				end
			end
		end
		for (int k = 0; k < 4; k++) begin
			if (form_st[k] == ST_MATCH && !res.hit) begin
				res.hit     = 1'b1;
				res.kind    = kind_t'(k);
				res.span    = form_end[k];
				res.value   = form_acc[k];
				res.minus   = minus_flag;
				res.wrapped = form_ovf[k];
			end
		end
		clear_scan();
		return 1'b1;
	endfunction

	task automatic send_char(logic [7:0] c, bit opens, bit closes);
		scan_result_t res;
		if (idling_on && $urandom_range(0, 7) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		item_valid <= 1'b1;
		character  <= c;
		first_char <= opens;
		last_char  <= closes;
		@(negedge clk);
		while (!item_ready)
			@(negedge clk);
		@(posedge clk);
		if (predict_scan(c, opens, closes, res))
			expected_literals.push_back(res);
		chars_sent++;
	endtask

	task automatic send_lit_chars(bit opens, bit closes);
		int n;
		n = lit_chars.size();
		for (int i = 0; i < n; i++)
			send_char(lit_chars[i], opens && i == 0, closes && i == n - 1);
		lit_chars.delete();
	endtask

	task automatic run_text(string s, bit opens);
		for (int i = 0; i < s.len(); i++)
			lit_chars.push_back(s[i]);
		send_lit_chars(opens, 1'b1);
	endtask

	function automatic logic [7:0] junk_char();
		string pool;
		int    sel;
		pool = "01789bxXfgA+- ";
		sel  = $urandom_range(0, 15);
		if (sel < pool.len())
			return pool[sel];
		return 8'($urandom_range(0, 255));
	endfunction

	// mostly well-formed literals with random digits, some noise and damage
	task automatic build_random_text();
		string hexset;
		int    n;
		hexset = "0123456789abcdefABCDEF";
		case ($urandom_range(0, 3))
			0: lit_chars.push_back(CH_PLUS);
			1: lit_chars.push_back(CH_MINUS);
			default: ;
		endcase
		case ($urandom_range(0, 9))
			0, 1: begin
				n = ($urandom_range(0, 29) == 0) ? $urandom_range(250, 258) : $urandom_range(1, 70);
				repeat (n) lit_chars.push_back(CH_ZERO + 8'($urandom_range(0, 1)));
				lit_chars.push_back(CH_B);
			end
			2, 3: begin
				lit_chars.push_back(CH_ZERO);
				repeat ($urandom_range(1, 27)) lit_chars.push_back(CH_ZERO + 8'($urandom_range(0, 7)));
			end
			4, 5: begin
				lit_chars.push_back(CH_ZERO);
				lit_chars.push_back(CH_X);
				repeat ($urandom_range(1, 23)) lit_chars.push_back(hexset[$urandom_range(0, 21)]);
			end
			6, 7: begin
				repeat ($urandom_range(1, 23)) lit_chars.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
			end
			default: begin
				repeat ($urandom_range(1, 6)) lit_chars.push_back(8'($urandom_range(0, 255)));
			end
		endcase
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) lit_chars.push_back(junk_char());
		if ($urandom_range(0, 7) == 0 && lit_chars.size() > 0)
			lit_chars[$urandom_range(0, lit_chars.size() - 1)] = junk_char();
	endtask

	task automatic test_directed();
		run_text("101b", 1'b1);
		run_text("-110b", 1'b1);
		run_text("+0b", 1'b0);
		run_text("0b1", 1'b1);
		run_text("017", 1'b1);
		run_text("0x1F", 1'b1);
		run_text("-0xaF", 1'b1);
		run_text("0XF", 1'b0);
		run_text("123", 1'b1);
		run_text("-0", 1'b1);
		run_text("+", 1'b1);
		run_text("abc", 1'b1);
		run_text("0x", 1'b1);
		run_text("08", 1'b1);
		run_text("1-2", 1'b1);
		run_text("2b", 1'b0);
		run_text("18446744073709551615", 1'b1);
		run_text("18446744073709551616", 1'b1);
		run_text("0x0123456789abcdefABCDEF", 1'b1);
		send_char(8'h00, 1'b1, 1'b1);
		send_char(8'hff, 1'b1, 1'b1);
	endtask

	task automatic test_repeat_limits();
		// longest binary with a sign: match length 258
		lit_chars.push_back(CH_MINUS);
		repeat (BIN_LIMIT) lit_chars.push_back(CH_ONE);
		lit_chars.push_back(CH_B);
		send_lit_chars(1'b1, 1'b1);
		// binary one digit too long, octal takes over at its limit
		repeat (BIN_LIMIT + 1) lit_chars.push_back(CH_ZERO);
		lit_chars.push_back(CH_B);
		send_lit_chars(1'b1, 1'b1);
		lit_chars.push_back(CH_ZERO);
		repeat (OCT_LIMIT + 1) lit_chars.push_back(CH_SEVEN);
		send_lit_chars(1'b1, 1'b1);
		repeat (DEC_LIMIT + 1) lit_chars.push_back(CH_NINE);
		send_lit_chars(1'b1, 1'b1);
		// position saturation
		repeat (600) lit_chars.push_back(CH_ZERO + 8'd5);
		send_lit_chars(1'b1, 1'b1);
	endtask

	task automatic random_texts(int count);
		int stop_at;
		stop_at = chars_sent + count;
		while (chars_sent < stop_at) begin
			build_random_text();
			send_lit_chars($urandom_range(0, 4) != 0, $urandom_range(0, 19) != 0);
		end
	endtask

	task automatic test_random_traffic();
		idling_on = 1'b1;
		random_texts(RANDOM_CHARS);
	endtask

	task automatic test_back_to_back();
		idling_on = 1'b0;
		random_texts(BURST_CHARS);
		run_text("42", 1'b1);
	endtask

	initial begin
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (idling_on && $urandom_range(0, 9) == 0) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
			result_ready <= 1'b1;
		end
	end

	always @(negedge clk) begin : check_results
		scan_result_t want;
		if (arst_n && result_valid === 1'b1 && result_ready) begin
			if (expected_literals.size() == 0) begin
				$error("result beat with no closed text pending");
				fail_count++;
			end else begin
				want = expected_literals.pop_front();
				if (matched !== want.hit) begin
					$error("matched: expected %0d, got %0d", want.hit, matched);
					fail_count++;
				end
				if (radix_kind !== want.kind) begin
					$error("radix_kind: expected %0d, got %0d", want.kind, radix_kind);
					fail_count++;
				end
				if (match_length !== want.span) begin
					$error("match_length: expected %0d, got %0d", want.span, match_length);
					fail_count++;
				end
				if (magnitude !== want.value) begin
					$error("magnitude: expected %h, got %h", want.value, magnitude);
					fail_count++;
				end
				if (negative !== want.minus) begin
					$error("negative: expected %0d, got %0d", want.minus, negative);
					fail_count++;
				end
				if (overflowed !== want.wrapped) begin
					$error("overflowed: expected %0d, got %0d", want.wrapped, overflowed);
					fail_count++;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if ((item_valid && item_ready) || (result_valid && result_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("integer_literal_scanner verification failed");
					$finish;
				end
			end
		end
	end

	initial begin
		arst_n     = 1'b0;
		item_valid = 1'b0;
		character  = '0;
		first_char = 1'b0;
		last_char  = 1'b0;
		clear_scan();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_repeat_limits();
		test_random_traffic();
		test_back_to_back();
		item_valid <= 1'b0;
		while (expected_literals.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("integer_literal_scanner verification clean");
		else
			$display("integer_literal_scanner verification failed");
		$finish;
	end

endmodule

### filelist.f
rtl/ils_pkg.sv
rtl/integer_literal_scanner.sv
tb/integer_literal_scanner_tb.sv
